>>> hdl/d8fra_pkg.sv
// ----------------------------------------------------------------------------
// d8fra_pkg
// Shared types and constants of the D8 flow routing and accumulation block.
// ----------------------------------------------------------------------------
`default_nettype none
package d8fra_pkg;

  localparam int unsigned MaxSide = 64;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned AccW   = 13;
  localparam int unsigned SideW  = 7;
  localparam int unsigned HW     = 24;
  localparam int unsigned DiagScale  = 46341;
  localparam int unsigned OrthoScale = 65536;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;
  localparam logic RESP_READ = 1'b0;
  localparam logic RESP_DONE = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [IdxW-1:0]  cell_index;
    logic signed [HW-1:0] height;
    logic             load_last;
  } req_t;

  typedef struct packed {
    logic             resp_kind;
    logic             has_downstream;
    logic [IdxW-1:0]  downstream_cell;
    logic [AccW-1:0]  accumulation;
    logic [AccW-1:0]  max_accumulation;
    logic             results_ready;
  } resp_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_INIT, ST_CENTER, ST_NBR, ST_NBR_WAIT, ST_ROUTE_WR, ST_ROUTE_INC,
    ST_SCAN, ST_SCAN_WAIT, ST_POP, ST_POP_CELL, ST_POP_TGT, ST_POP_WAIT,
    ST_MAX, ST_MAX_WAIT, ST_READ_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic init_start;   // start init sweep
    logic init_step;
    logic ctr_clr;      // clear cell counter
    logic ctr_inc;
    logic nbr_clr;
    logic nbr_inc;
    logic center_rd;
    logic nbr_rd;
    logic nbr_eval;
    logic route_wr;
    logic route_inc;
    logic scan_rd;
    logic scan_eval;
    logic pop_rd;
    logic cell_rd;
    logic tgt_rd;
    logic pop_eval;
    logic max_rd;
    logic max_eval;
    logic host_load;
    logic host_rd;
    logic resp_done;
    logic resp_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic ctr_last;
    logic nbr_last;
    logic queue_empty;
  } sts_t;

endpackage
`default_nettype wire

>>> hdl/d8fra_ctrl.sv
// ----------------------------------------------------------------------------
// d8fra_ctrl
// Sequencer: loads, reads, and the routing and accumulation passes.
// ----------------------------------------------------------------------------
`default_nettype none
module d8fra_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire d8fra_pkg::req_t in_data_i,
  input  wire logic            out_busy_i,
  input  wire d8fra_pkg::sts_t sts_i,
  output d8fra_pkg::cmd_t      cmd_o
);
  import d8fra_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = !out_busy_i;
        if (in_valid_i && !out_busy_i) begin
          if (in_data_i.req_type == REQ_LOAD) begin
            cmd_o.host_load = 1'b1;
            if (in_data_i.load_last) begin
              cmd_o.init_start = 1'b1;
              cmd_o.ctr_clr    = 1'b1;
              state_d = ST_INIT;
            end
          end else begin
            cmd_o.host_rd = 1'b1;
            state_d = ST_READ_WAIT;
          end
        end
      end
      ST_READ_WAIT: begin
        cmd_o.resp_read = 1'b1;
        cmd_o.out_load  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        cmd_o.ctr_inc   = 1'b1;
        if (sts_i.ctr_last) begin
          cmd_o.ctr_clr = 1'b1;
          cmd_o.ctr_inc = 1'b0;
          state_d = ST_CENTER;
        end
      end
      ST_CENTER: begin
        cmd_o.center_rd = 1'b1;
        cmd_o.nbr_clr   = 1'b1;
        state_d = ST_NBR;
      end
      ST_NBR: begin
        cmd_o.nbr_rd = 1'b1;
        state_d = ST_NBR_WAIT;
      end
      ST_NBR_WAIT: begin
        cmd_o.nbr_eval = 1'b1;
        cmd_o.nbr_inc  = 1'b1;
        state_d = sts_i.nbr_last ? ST_ROUTE_WR : ST_NBR;
      end
      ST_ROUTE_WR: begin
        cmd_o.route_wr = 1'b1;
        state_d = ST_ROUTE_INC;
      end
      ST_ROUTE_INC: begin
        cmd_o.route_inc = 1'b1;
        if (sts_i.ctr_last) begin
          cmd_o.ctr_clr = 1'b1;
          state_d = ST_SCAN;
        end else begin
          cmd_o.ctr_inc = 1'b1;
          state_d = ST_CENTER;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        state_d = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        cmd_o.scan_eval = 1'b1;
        if (sts_i.ctr_last) begin
          cmd_o.ctr_clr = 1'b1;
          state_d = ST_POP;
        end else begin
          cmd_o.ctr_inc = 1'b1;
          state_d = ST_SCAN;
        end
      end
      ST_POP: begin
        if (sts_i.queue_empty) begin
          state_d = ST_MAX;
        end else begin
          cmd_o.pop_rd = 1'b1;
          state_d = ST_POP_CELL;
        end
      end
      ST_POP_CELL: begin
        cmd_o.cell_rd = 1'b1;
        state_d = ST_POP_TGT;
      end
      ST_POP_TGT: begin
        cmd_o.tgt_rd = 1'b1;
        state_d = ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        cmd_o.pop_eval = 1'b1;
        state_d = ST_POP;
      end
      ST_MAX: begin
        cmd_o.max_rd = 1'b1;
        state_d = ST_MAX_WAIT;
      end
      ST_MAX_WAIT: begin
        cmd_o.max_eval = 1'b1;
        if (sts_i.ctr_last) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.ctr_inc = 1'b1;
          state_d = ST_MAX;
        end
      end
      ST_OUT: begin
        cmd_o.resp_done = 1'b1;
        cmd_o.out_load  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  ap_out_from_known_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (state_q == ST_OUT || state_q == ST_READ_WAIT))
    else $error("result loaded outside a response state");
  ap_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("input taken while busy");
  ap_read_then_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.host_rd |=> state_q == ST_READ_WAIT)
    else $error("read lost its response cycle");

endmodule
`default_nettype wire

>>> hdl/d8fra_datapath.sv
// ----------------------------------------------------------------------------
// d8fra_datapath
// Grid memories, neighbor slope compare, inflow counts, cell queue, and max.
// ----------------------------------------------------------------------------
`default_nettype none
module d8fra_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire d8fra_pkg::cmd_t       cmd_i,
  input  wire d8fra_pkg::req_t       req_i,
  input  wire logic [d8fra_pkg::SideW-1:0] grid_side_i,
  output d8fra_pkg::sts_t            sts_o,
  output d8fra_pkg::resp_t           resp_o
);
  import d8fra_pkg::*;

  localparam int unsigned Cells = MaxSide * MaxSide;
  localparam int unsigned CW    = $clog2(Cells);
  localparam int unsigned SW    = $clog2(MaxSide + 1);
  localparam int unsigned XW    = $clog2(MaxSide);
  localparam int unsigned SlW   = HW + 18;

  logic signed [HW-1:0] hmem [Cells];
  logic [CW:0]          dmem [Cells];
  logic [AccW-1:0]      amem [Cells];
  logic [3:0]           pmem [Cells];
  logic [CW-1:0]        qmem [Cells];

  logic [SW-1:0] side;
  logic [CW:0]   cells_q, cells_d;
  logic [CW:0]   ctr_q;
  logic [XW-1:0] x_q, y_q;
  logic [3:0]    nbr_q;
  logic [CW:0]   head_q, tail_q;
  logic          done_q;
  logic [AccW-1:0] max_q, pass_max_q;
  logic [CW:0]   pass_cells_q;
  resp_t         resp_q, resp_d;

  logic signed [HW-1:0] h_rd_q, here_q;
  logic [CW:0]   d_rd_q;
  logic [AccW-1:0] a_rd_q;
  logic [3:0]    p_rd_q;
  logic [CW-1:0] nidx_q;
  logic          nvalid_q, ndiag_q;
  logic [SlW-1:0] best_q;
  logic [CW:0]   bestd_q;
  logic [CW-1:0] cur_q;
  logic [CW:0]   pop_ds_q;
  logic [AccW-1:0] a_tgt_q;
  logic [AccW-1:0] a_cur_q;

  // clamp side
  always_comb begin
    if (grid_side_i < SideW'(2)) begin
      side = SW'(2);
    end else if (32'(grid_side_i) > MaxSide) begin
      side = SW'(MaxSide);
    end else begin
      side = SW'(grid_side_i);
    end
    cells_d = {{(CW+1-SW){1'b0}}, side} * {{(CW+1-SW){1'b0}}, side};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_start) begin
      cells_q <= cells_d;
    end
  end

  logic [CW:0] ctr_end;
  assign ctr_end = cells_q - 1'b1;
  assign sts_o.ctr_last    = (ctr_q == ctr_end);
  assign sts_o.nbr_last    = (nbr_q == 4'd7);
  assign sts_o.queue_empty = (head_q == tail_q) || (head_q >= cells_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q <= '0;
      x_q   <= '0;
      y_q   <= '0;
      nbr_q <= '0;
    end else begin
      if (cmd_i.ctr_clr) begin
        ctr_q <= '0;
        x_q   <= '0;
        y_q   <= '0;
      end else if (cmd_i.ctr_inc) begin
        ctr_q <= ctr_q + 1'b1;
        if ((SW)'(x_q) == side - 1'b1) begin
          x_q <= '0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      if (cmd_i.nbr_clr) begin
        nbr_q <= '0;
      end else if (cmd_i.nbr_inc) begin
        nbr_q <= nbr_q + 1'b1;
      end
    end
  end

  // neighbor offset in row-major order, skipping center
  logic [1:0] oxs, oys;
  logic signed [XW+1:0] nx, ny;
  logic nin;
  logic [CW:0] nlin;
  always_comb begin
    case (nbr_q)
      4'd0: begin oys = 2'd0; oxs = 2'd0; end
      4'd1: begin oys = 2'd0; oxs = 2'd1; end
      4'd2: begin oys = 2'd0; oxs = 2'd2; end
      4'd3: begin oys = 2'd1; oxs = 2'd0; end
      4'd4: begin oys = 2'd1; oxs = 2'd2; end
      4'd5: begin oys = 2'd2; oxs = 2'd0; end
      4'd6: begin oys = 2'd2; oxs = 2'd1; end
      default: begin oys = 2'd2; oxs = 2'd2; end
    endcase
    nx  = $signed({2'b00, x_q}) + $signed({{XW{1'b0}}, oxs}) - (XW+2)'(1);
    ny  = $signed({2'b00, y_q}) + $signed({{XW{1'b0}}, oys}) - (XW+2)'(1);
    nin = !nx[XW+1] && !ny[XW+1] && (nx < $signed({1'b0, side}))
          && (ny < $signed({1'b0, side}));
    nlin = (CW+1)'($unsigned(ny)) * (CW+1)'(side) + (CW+1)'($unsigned(nx));
  end

  // slope of registered neighbor
  logic signed [HW:0] drop;
  logic [SlW-1:0] slope;
  always_comb begin
    drop  = (HW+1)'(here_q) - (HW+1)'(h_rd_q);
    slope = ndiag_q ? SlW'($unsigned(drop[HW-1:0])) * SlW'(DiagScale)
                    : SlW'($unsigned(drop[HW-1:0])) << 16;
  end

  logic [CW-1:0] pop_tgt;
  logic [CW-1:0] host_idx;
  assign pop_tgt  = pop_ds_q[CW-1:0];
  assign host_idx = req_i.cell_index[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.nbr_rd) begin
      nidx_q   <= nlin[CW-1:0];
      nvalid_q <= nin;
      ndiag_q  <= (oxs != 2'd1) && (oys != 2'd1);
    end
    if (cmd_i.center_rd) begin
      best_q  <= '0;
      bestd_q <= '0;
    end else if (cmd_i.nbr_eval && nvalid_q && !drop[HW] && drop != '0
                 && slope > best_q) begin
      best_q  <= slope;
      bestd_q <= {1'b1, nidx_q};
    end
  end

  // heights
  always_ff @(posedge clk_i) begin
    if (cmd_i.host_load) begin
      hmem[host_idx] <= req_i.height;
    end
    if (cmd_i.center_rd) begin
      here_q <= hmem[ctr_q[CW-1:0]];
    end
    if (cmd_i.nbr_rd) begin
      h_rd_q <= hmem[nlin[CW-1:0]];
    end
  end

  // downstream links
  always_ff @(posedge clk_i) begin
    if (cmd_i.route_wr) begin
      dmem[ctr_q[CW-1:0]] <= bestd_q;
    end
    if (cmd_i.host_rd) begin
      d_rd_q <= dmem[host_idx];
    end
    if (cmd_i.cell_rd) begin
      pop_ds_q <= dmem[cur_q];
    end
  end

  // accumulation
  logic            a_we;
  logic [CW-1:0]   a_waddr;
  logic [AccW-1:0] a_wdata;
  always_comb begin
    a_we    = 1'b0;
    a_waddr = ctr_q[CW-1:0];
    a_wdata = AccW'(1);
    if (cmd_i.init_step) begin
      a_we = 1'b1;
    end else if (cmd_i.pop_eval && pop_ds_q[CW]) begin
      a_we    = 1'b1;
      a_waddr = pop_tgt;
      a_wdata = a_tgt_q + a_cur_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_we) begin
      amem[a_waddr] <= a_wdata;
    end
    if (cmd_i.host_rd) begin
      a_rd_q <= amem[host_idx];
    end else if (cmd_i.max_rd) begin
      a_rd_q <= amem[ctr_q[CW-1:0]];
    end
    if (cmd_i.cell_rd) begin
      a_cur_q <= amem[cur_q];
    end
    if (cmd_i.tgt_rd) begin
      a_tgt_q <= amem[pop_tgt];
    end
  end

  // inflow counts
  logic          p_we;
  logic [CW-1:0] p_waddr;
  logic [3:0]    p_wdata;
  always_comb begin
    p_we    = 1'b0;
    p_waddr = ctr_q[CW-1:0];
    p_wdata = '0;
    if (cmd_i.init_step) begin
      p_we = 1'b1;
    end else if (cmd_i.route_inc && bestd_q[CW]) begin
      p_we    = 1'b1;
      p_waddr = bestd_q[CW-1:0];
      p_wdata = p_rd_q + 4'd1;
    end else if (cmd_i.pop_eval && pop_ds_q[CW] && p_rd_q != 4'd0) begin
      p_we    = 1'b1;
      p_waddr = pop_tgt;
      p_wdata = p_rd_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    if (cmd_i.route_wr) begin
      p_rd_q <= pmem[bestd_q[CW-1:0]];
    end else if (cmd_i.scan_rd) begin
      p_rd_q <= pmem[ctr_q[CW-1:0]];
    end else if (cmd_i.tgt_rd) begin
      p_rd_q <= pmem[pop_tgt];
    end
  end

  // ready cell queue
  logic          scan_push;
  logic          push_pop;
  logic          q_we;
  logic [CW-1:0] q_wdata;
  assign scan_push = cmd_i.scan_eval && p_rd_q == 4'd0;
  assign push_pop  = cmd_i.pop_eval && pop_ds_q[CW] && p_rd_q == 4'd1
                     && tail_q < cells_q;
  assign q_we      = scan_push || push_pop;
  assign q_wdata   = scan_push ? ctr_q[CW-1:0] : pop_tgt;

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[tail_q[CW-1:0]] <= q_wdata;
    end
    if (cmd_i.pop_rd) begin
      cur_q <= qmem[head_q[CW-1:0]];
    end else if (cmd_i.host_rd) begin
      cur_q <= host_idx;
    end
  end

  always_comb begin
    resp_d = '0;
    if (cmd_i.resp_done) begin
      resp_d.resp_kind        = RESP_DONE;
      resp_d.max_accumulation = max_q;
      resp_d.results_ready    = 1'b1;
    end else begin
      resp_d.resp_kind = RESP_READ;
      if (done_q) begin
        resp_d.max_accumulation = pass_max_q;
        resp_d.results_ready    = 1'b1;
        if ({1'b0, cur_q} < pass_cells_q) begin
          resp_d.has_downstream  = d_rd_q[CW];
          resp_d.downstream_cell = d_rd_q[CW] ? IdxW'(d_rd_q[CW-1:0]) : '0;
          resp_d.accumulation    = a_rd_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      max_q  <= '0;
      pass_max_q <= '0;
      pass_cells_q <= '0;
      done_q <= 1'b0;
      resp_q <= '0;
    end else begin
      if (cmd_i.init_start) begin
        head_q <= '0;
        tail_q <= '0;
        max_q  <= '0;
      end else begin
        if (q_we) begin
          tail_q <= tail_q + 1'b1;
        end
        if (cmd_i.pop_rd) begin
          head_q <= head_q + 1'b1;
        end
        if (cmd_i.max_eval && a_rd_q > max_q) begin
          max_q <= a_rd_q;
        end
      end
      if (cmd_i.resp_done) begin
        pass_max_q   <= max_q;
        pass_cells_q <= cells_q;
        done_q       <= 1'b1;
      end
      if (cmd_i.resp_done || cmd_i.resp_read) begin
        resp_q <= resp_d;
      end
    end
  end

  assign resp_o = resp_q;

  ap_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q || head_q == '0)
    else $error("queue head passed tail");
  ap_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(done_q) |-> done_q)
    else $error("done flag dropped");
  ap_done_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.resp_done |=> resp_q.results_ready)
    else $error("finish response without ready flag");

endmodule
`default_nettype wire

>>> hdl/d8_flow_routing_accumulation.sv
// ----------------------------------------------------------------------------
// d8_flow_routing_accumulation
// D8 flow routing and flow accumulation over a square height grid.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): one transfer loads one
// height or requests one cell's results. A load with load_last set starts a
// pass; its transfer returns one finish result. A read returns one result.
// Output channel (out_valid_o/out_ready_i, out_data_o): one result register;
// input is taken only while it is empty or drains in the same cycle.
// A read result is loaded into the output register from the read-wait
// state; a new transfer is taken only once the controller is back in idle.
// Plain loads return nothing. A pass runs its steps in order: init of every
// cell, routing per cell (center read, 8 neighbor read/compare pairs, link
// write, inflow update), the scan, the queue pops, and the max. grid_side
// is written through the APB port at address 0; the user must do so only
// while idle, and the block itself does not enforce it.
// A stalled receiver holds the result and blocks further input.
// Reset clears the controller, queue pointers, the max and done flags; grid
// memories hold garbage until written by a load or a pass.
// ----------------------------------------------------------------------------
`default_nettype none
module d8_flow_routing_accumulation (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire d8fra_pkg::req_t   in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output d8fra_pkg::resp_t       out_data_o
);
  import d8fra_pkg::*;

  logic [SideW-1:0] grid_side_q;
  logic             out_valid_q;
  logic             out_busy;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign prdata = {25'd0, grid_side_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= SideW'(64);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      grid_side_q <= pwdata[SideW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end
  assign out_valid_o = out_valid_q;
  assign out_busy    = out_valid_q && !out_ready_i;

  d8fra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_busy_i (out_busy),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  d8fra_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (in_data_i),
    .grid_side_i (grid_side_q),
    .sts_o       (sts),
    .resp_o      (out_data_o)
  );

endmodule
`default_nettype wire

>>> test/d8_flow_routing_accumulation_tb.sv
// ----------------------------------------------------------------------------
// d8_flow_routing_accumulation_tb
// Self-checking bench for the D8 flow routing and accumulation block.
// Loads height grids of several sides, triggers routing passes and reads
// back downstream and accumulation of random cells. A behavioral flow model
// predicts every response, and a monitor compares them field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module d8_flow_routing_accumulation_tb;
  import d8fra_pkg::*;

  localparam int unsigned NumCells  = MaxSide * MaxSide;
  localparam int unsigned StallLimit = 250000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid_i, in_ready_o;
  req_t        in_data_i;
  logic        out_valid_o, out_ready_i;
  resp_t       out_data_o;

  d8_flow_routing_accumulation uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .in_data_i, .out_valid_o, .out_ready_i, .out_data_o
  );

  // flow model state
  int          height_mem [NumCells];
  bit          route_valid [NumCells];
  int          route_cell [NumCells];
  int          accum_mem [NumCells];
  int          inflow_cnt [NumCells];
  int          ready_list [NumCells];
  int          max_accum;
  bit          pass_done;
  int          pass_cells;
  logic [6:0]  side_reg;
  bit          loaded [NumCells];

  req_t        pending_q[$];
  resp_t       expected_q[$];
  int          send_idle, recv_stall;
  int          fail_count;
  int          quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clamp_side(logic [6:0] v);
    if (v < 2) return 2;
    if (v > MaxSide) return MaxSide;
    return int'(v);
  endfunction

  function automatic void route_grid(int n);
    int        head, tail, c, t, nx, ny;
    longint    here, best, drop, slope;
    head = 0;
    tail = 0;
    for (int i = 0; i < n * n; i++) begin
      accum_mem[i] = 1;
      inflow_cnt[i] = 0;
    end
    for (int y = 0; y < n; y++) begin
      for (int x = 0; x < n; x++) begin
        here = height_mem[y * n + x];
        best = 0;
        route_valid[y * n + x] = 1'b0;
        route_cell[y * n + x] = 0;
        for (int oy = -1; oy <= 1; oy++) begin
          for (int ox = -1; ox <= 1; ox++) begin
            nx = x + ox;
            ny = y + oy;
            if ((ox == 0 && oy == 0) || nx < 0 || ny < 0 || nx >= n || ny >= n) continue;
            drop = here - longint'(height_mem[ny * n + nx]);
            if (drop <= 0) continue;
            slope = drop * ((ox == 0 || oy == 0) ? longint'(OrthoScale) : longint'(DiagScale));
            if (slope > best) begin
              best = slope;
              route_valid[y * n + x] = 1'b1;
              route_cell[y * n + x] = ny * n + nx;
            end
          end
        end
      end
    end
    for (int i = 0; i < n * n; i++)
      if (route_valid[i]) inflow_cnt[route_cell[i]]++;
    for (int i = 0; i < n * n; i++)
      if (inflow_cnt[i] == 0) ready_list[tail++] = i;
    while (head < tail) begin
      c = ready_list[head++];
      if (route_valid[c]) begin
        t = route_cell[c];
        accum_mem[t] += accum_mem[c];
        if (inflow_cnt[t] > 0) begin
          inflow_cnt[t]--;
          if (inflow_cnt[t] == 0) ready_list[tail++] = t;
        end
      end
    end
    max_accum = 0;
    for (int i = 0; i < n * n; i++)
      if (accum_mem[i] > max_accum) max_accum = accum_mem[i];
    pass_cells = n * n;
    pass_done = 1'b1;
  endfunction

  function automatic void predict_transfer(req_t r);
    resp_t e;
    int    idx;
    e = '0;
    idx = int'(r.cell_index);
    if (r.req_type == REQ_LOAD) begin
      height_mem[idx] = int'(r.height);
      if (!r.load_last) return;
      route_grid(clamp_side(side_reg));
      e.resp_kind = RESP_DONE;
      e.max_accumulation = max_accum[AccW-1:0];
      e.results_ready = 1'b1;
    end else if (pass_done) begin
      e.resp_kind = RESP_READ;
      if (idx < pass_cells) begin
        e.has_downstream = route_valid[idx];
        e.downstream_cell = route_valid[idx] ? route_cell[idx][IdxW-1:0] : '0;
        e.accumulation = accum_mem[idx][AccW-1:0];
      end
      e.max_accumulation = max_accum[AccW-1:0];
      e.results_ready = 1'b1;
    end
    expected_q.push_back(e);
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) predict_transfer(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data_i <= pending_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall);
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          if (out_data_o.resp_kind !== expected_q[0].resp_kind)
            report_mismatch("resp_kind", out_data_o.resp_kind, expected_q[0].resp_kind);
          if (out_data_o.has_downstream !== expected_q[0].has_downstream)
            report_mismatch("has_downstream", out_data_o.has_downstream,
                            expected_q[0].has_downstream);
          if (out_data_o.downstream_cell !== expected_q[0].downstream_cell)
            report_mismatch("downstream_cell", out_data_o.downstream_cell,
                            expected_q[0].downstream_cell);
          if (out_data_o.accumulation !== expected_q[0].accumulation)
            report_mismatch("accumulation", out_data_o.accumulation,
                            expected_q[0].accumulation);
          if (out_data_o.max_accumulation !== expected_q[0].max_accumulation)
            report_mismatch("max_accumulation", out_data_o.max_accumulation,
                            expected_q[0].max_accumulation);
          if (out_data_o.results_ready !== expected_q[0].results_ready)
            report_mismatch("results_ready", out_data_o.results_ready,
                            expected_q[0].results_ready);
          void'(expected_q.pop_front());
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_side(logic [6:0] v);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 2'd0;
    pwdata <= {25'd0, v};
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    side_reg = v;
  endtask

  task automatic push_load(int idx, int h, bit last);
    req_t r;
    r.req_type = REQ_LOAD;
    r.cell_index = idx[IdxW-1:0];
    r.height = h[HW-1:0];
    r.load_last = last;
    loaded[idx] = 1'b1;
    pending_q.push_back(r);
  endtask

  task automatic push_read(int idx);
    req_t r;
    r.req_type = REQ_READ;
    r.cell_index = idx[IdxW-1:0];
    r.height = $urandom();
    r.load_last = $urandom_range(1);
    pending_q.push_back(r);
  endtask

  task automatic drain(int tail_cycles);
    while (pending_q.size() > 0 || expected_q.size() > 0 || in_valid_i) @(posedge clk_i);
    repeat (tail_cycles) @(posedge clk_i);
  endtask

  function automatic int pick_height(int style);
    case (style)
      0: return $urandom_range(3);
      1: return int'($urandom()) >>> 8;
      2: return $urandom_range(255) - 128;
      default: begin
        case ($urandom_range(3))
          0: return -8388608;
          1: return 8388607;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // one load set, one pass, then reads and stray loads
  task automatic run_grid(logic [6:0] side_v, int style, bit reload_all);
    int n;
    write_side(side_v);
    n = clamp_side(side_v);
    for (int i = 0; i < n * n; i++)
      if (reload_all || !loaded[i] || $urandom_range(15) == 0)
        push_load(i, pick_height(style), 1'b0);
    push_load($urandom_range(n * n - 1), pick_height(style), 1'b1);
    for (int i = 0; i < n * n / 2 + 6; i++) begin
      if ($urandom_range(9) == 0) begin
        push_read($urandom_range(NumCells - 1));
      end else if ($urandom_range(11) == 0) begin
        push_load($urandom_range(NumCells - 1), pick_height(1), 1'b0);
      end else begin
        push_read($urandom_range(n * n - 1));
      end
    end
    drain(8);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 0;
    recv_stall = 0;
    fail_count = 0;
    quiet_cycles = 0;
    pass_done = 1'b0;
    pass_cells = 0;
    max_accum = 0;
    side_reg = 7'd64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reads before any pass, extremes on a 2x2 grid
    write_side(7'd2);
    push_read(0);
    push_read(NumCells - 1);
    push_load(0, 8388607, 1'b0);
    push_load(1, -8388608, 1'b0);
    push_load(2, 0, 1'b0);
    push_load(3, -1, 1'b1);
    for (int i = 0; i < 5; i++) push_read(i);
    push_read(NumCells - 1);
    drain(8);

    // plateau, then tie between diagonal and orthogonal slopes
    write_side(7'd3);
    for (int i = 0; i < 9; i++) push_load(i, 100, i == 8);
    push_read(4);
    push_read(0);
    for (int i = 0; i < 9; i++) push_load(i, 500000, 1'b0);
    push_load(4, 131072, 1'b0);
    push_load(0, 65536, 1'b0);
    push_load(1, 131072 - 46341, 1'b1);
    push_read(4);
    push_read(1);
    push_read(8);
    drain(8);

    // larger grids, then side clamped from below
    run_grid(7'd16, 1, 1'b1);
    recv_stall = 57;
    run_grid(7'd12, 0, 1'b0);
    run_grid(7'd0, 3, 1'b1);
    run_grid(7'd1, 2, 1'b1);

    for (int ph = 0; ph < 20; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 57; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 57; end
        default: begin send_idle = 28; recv_stall = 28; end
      endcase
      run_grid(7'($urandom_range(2, 8)), $urandom_range(3), $urandom_range(1));
    end
    send_idle = 0;
    recv_stall = 0;
    run_grid(7'd2, 1, 1'b1);

    drain(20);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
